FILE: rtl/bmpsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmpsd_pkg
// Shared types and constants of the BMP stream decoder.
// ---------------------------------------------------------------------------
package bmpsd_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAL_DW          = 32;

  localparam logic [15:0] SIGNATURE   = 16'h4d42;
  localparam logic [31:0] HEADERS_END = 32'd54;
  localparam logic [31:0] PALETTE_END = 32'd1078;
  localparam logic [31:0] INFO_SIZE   = 32'd40;
  localparam logic [15:0] DEPTH_8     = 16'd8;
  localparam logic [15:0] DEPTH_24    = 16'd24;
  localparam logic [31:0] COMPR_MAX   = 32'd2;

  // last byte of each checked header field
  localparam logic [10:0] POS_SIGNATURE   = 11'd1;
  localparam logic [10:0] POS_FILE_SIZE   = 11'd5;
  localparam logic [10:0] POS_DATA_OFFSET = 11'd13;
  localparam logic [10:0] POS_INFO_SIZE   = 11'd17;
  localparam logic [10:0] POS_WIDTH       = 11'd21;
  localparam logic [10:0] POS_HEIGHT      = 11'd25;
  localparam logic [10:0] POS_DEPTH       = 11'd29;
  localparam logic [10:0] POS_COMPRESSION = 11'd33;
  localparam logic [10:0] POS_HEADER_LAST = 11'd53;
  localparam logic [10:0] POS_PAL_LAST    = 11'd1077;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SIGNATURE   = 3'd1,
    ERR_ZERO_SIZE   = 3'd2,
    ERR_OFFSET      = 3'd3,
    ERR_INFO_SIZE   = 3'd4,
    ERR_DEPTH       = 3'd5,
    ERR_COMPRESSION = 3'd6,
    ERR_TOO_LARGE   = 3'd7
  } err_code_t;

  typedef struct packed {
    logic             kind;
    logic [19:0]      addr;
    logic [31:0]      color;
    err_code_t        err;
    logic [10:0]      width;
    logic [10:0]      height;
    logic             last;
    logic             use_pal;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [PAL_DW-1:0] data;
  } pal_wr_t;

  typedef struct packed {
    logic              re;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

endpackage

`default_nettype wire

FILE: rtl/bmpsd_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmpsd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bmpsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmpsd_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmpsd_parser
// Header checks, palette load addressing and pixel assembly for one byte.
// ---------------------------------------------------------------------------
module bmpsd_parser #(
  parameter int MAX_WIDTH  = bmpsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmpsd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_start_of_file,
  output logic                     res_valid,
  output bmpsd_pkg::result_t       res,
  output bmpsd_pkg::pal_wr_t       pal_wr,
  output bmpsd_pkg::pal_rd_t       pal_rd
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PALETTE = 4'b0010,
    PH_PIXELS  = 4'b0100,
    PH_IDLE    = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_c, phase_nxt;
  logic [10:0] pos_r, pos_c, pos_nxt;
  logic [31:0] field_r, field_c, field_nxt;
  logic [WW-1:0] width_r, width_c, width_nxt;
  logic [HW-1:0] height_r, height_c, height_nxt;
  logic        wide_r, wide_c, wide_nxt;
  logic        tall_r, tall_c, tall_nxt;
  logic        is8_r, is8_c, is8_nxt;
  logic [HW-1:0] row_r, row_c, row_nxt;
  logic [WW-1:0] col_r, col_c, col_nxt;
  logic [1:0]  pbi_r, pbi_c, pbi_nxt;
  logic [15:0] partial_r, partial_c, partial_nxt;
  logic [1:0]  pad_r, pad_c, pad_nxt;
  logic [19:0] base_r, base_nxt;

  logic [31:0] field_shift;
  logic [10:0] pal_off;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [1:0]  width_low;
  logic [31:0] base_prod;
  logic        pix_emit;
  logic        pix_pal;
  logic [31:0] pix_color;
  bmpsd_pkg::err_code_t err;

  // restart takes effect before the byte that carries it is parsed
  assign phase_c   = in_start_of_file ? PH_HEADER : phase_r;
  assign pos_c     = in_start_of_file ? '0 : pos_r;
  assign field_c   = in_start_of_file ? '0 : field_r;
  assign width_c   = in_start_of_file ? '0 : width_r;
  assign height_c  = in_start_of_file ? '0 : height_r;
  assign wide_c    = in_start_of_file ? 1'b0 : wide_r;
  assign tall_c    = in_start_of_file ? 1'b0 : tall_r;
  assign is8_c     = in_start_of_file ? 1'b0 : is8_r;
  assign row_c     = in_start_of_file ? '0 : row_r;
  assign col_c     = in_start_of_file ? '0 : col_r;
  assign pbi_c     = in_start_of_file ? '0 : pbi_r;
  assign partial_c = in_start_of_file ? '0 : partial_r;
  assign pad_c     = in_start_of_file ? '0 : pad_r;

  assign field_shift = {in_data_byte, field_c[31:8]};
  assign pal_off     = pos_c - 11'(bmpsd_pkg::HEADERS_END);
  assign col_inc     = col_c + WW'(1);
  assign row_inc     = row_c + HW'(1);
  assign width_low   = 2'(width_c);
  assign base_prod   = 32'(height_c - HW'(1)) * 32'(width_c);

  always_comb begin
    phase_nxt   = phase_c;
    pos_nxt     = pos_c;
    field_nxt   = field_c;
    width_nxt   = width_c;
    height_nxt  = height_c;
    wide_nxt    = wide_c;
    tall_nxt    = tall_c;
    is8_nxt     = is8_c;
    row_nxt     = row_c;
    col_nxt     = col_c;
    pbi_nxt     = pbi_c;
    partial_nxt = partial_c;
    pad_nxt     = pad_c;
    base_nxt    = base_r;
    err         = bmpsd_pkg::ERR_NONE;
    pix_emit    = 1'b0;
    pix_pal     = 1'b0;
    pix_color   = '0;
    res_valid   = 1'b0;
    res         = '0;
    pal_wr      = '0;
    pal_rd      = '0;

    unique case (phase_c)
      PH_HEADER: begin
        field_nxt = field_shift;
        case (pos_c)
          bmpsd_pkg::POS_SIGNATURE: begin
            if (field_shift[31:16] != bmpsd_pkg::SIGNATURE) err = bmpsd_pkg::ERR_SIGNATURE;
          end
          bmpsd_pkg::POS_FILE_SIZE: begin
            if (field_shift == '0) err = bmpsd_pkg::ERR_ZERO_SIZE;
          end
          bmpsd_pkg::POS_DATA_OFFSET: begin
            if (field_shift != bmpsd_pkg::HEADERS_END && field_shift != bmpsd_pkg::PALETTE_END)
              err = bmpsd_pkg::ERR_OFFSET;
          end
          bmpsd_pkg::POS_INFO_SIZE: begin
            if (field_shift != bmpsd_pkg::INFO_SIZE) err = bmpsd_pkg::ERR_INFO_SIZE;
          end
          bmpsd_pkg::POS_WIDTH: begin
            width_nxt = WW'(field_shift);
            wide_nxt  = field_shift > 32'(MAX_WIDTH);
          end
          bmpsd_pkg::POS_HEIGHT: begin
            height_nxt = HW'(field_shift);
            tall_nxt   = field_shift > 32'(MAX_HEIGHT);
          end
          bmpsd_pkg::POS_DEPTH: begin
            if (field_shift[31:16] != bmpsd_pkg::DEPTH_8 &&
                field_shift[31:16] != bmpsd_pkg::DEPTH_24) begin
              err = bmpsd_pkg::ERR_DEPTH;
            end else begin
              is8_nxt = field_shift[31:16] == bmpsd_pkg::DEPTH_8;
            end
          end
          bmpsd_pkg::POS_COMPRESSION: begin
            if (field_shift > bmpsd_pkg::COMPR_MAX) err = bmpsd_pkg::ERR_COMPRESSION;
            else if (wide_c || tall_c) err = bmpsd_pkg::ERR_TOO_LARGE;
          end
          default: ;
        endcase
        if (err != bmpsd_pkg::ERR_NONE) begin
          phase_nxt = PH_IDLE;
          res_valid = in_fire;
          res.kind  = bmpsd_pkg::KIND_ERROR;
          res.err   = err;
        end else begin
          pos_nxt = pos_c + 11'd1;
          if (pos_c == bmpsd_pkg::POS_HEADER_LAST) begin
            base_nxt = 20'(base_prod);
            if (width_c == '0 || height_c == '0) phase_nxt = PH_IDLE;
            else if (is8_c) phase_nxt = PH_PALETTE;
            else phase_nxt = PH_PIXELS;
          end
        end
      end
      PH_PALETTE: begin
        field_nxt = field_shift;
        if (pal_off[1:0] == 2'd3) begin
          pal_wr.we   = in_fire;
          pal_wr.addr = pal_off[bmpsd_pkg::PAL_AW+1:2];
          pal_wr.data = field_shift;
        end
        pos_nxt = pos_c + 11'd1;
        if (pos_c == bmpsd_pkg::POS_PAL_LAST) phase_nxt = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (pad_c != 2'd0) begin
          pad_nxt = pad_c - 2'd1;
        end else if (is8_c) begin
          pix_emit    = 1'b1;
          pix_pal     = 1'b1;
          pal_rd.re   = in_fire;
          pal_rd.addr = in_data_byte[bmpsd_pkg::PAL_AW-1:0];
        end else begin
          case (pbi_c)
            2'd0: begin
              partial_nxt = {8'h00, in_data_byte};
              pbi_nxt     = 2'd1;
            end
            2'd1: begin
              partial_nxt = {in_data_byte, partial_c[7:0]};
              pbi_nxt     = 2'd2;
            end
            default: begin
              pbi_nxt   = 2'd0;
              pix_emit  = 1'b1;
              pix_color = {8'h00, in_data_byte, partial_c};
            end
          endcase
        end
        if (pix_emit) begin
          res_valid   = in_fire;
          res.kind    = bmpsd_pkg::KIND_PIXEL;
          res.addr    = base_r + 20'(col_c);
          res.color   = pix_color;
          res.use_pal = pix_pal;
          res.width   = 11'(width_c);
          res.height  = 11'(height_c);
          if (col_inc >= width_c) begin
            col_nxt  = '0;
            row_nxt  = row_inc;
            base_nxt = base_r - 20'(width_c);
            if (row_inc >= height_c) begin
              res.last  = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              pad_nxt = is8_c ? 2'd0 - width_low : width_low;
            end
          end else begin
            col_nxt = col_inc;
          end
        end
      end
      PH_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      field_r   <= '0;
      width_r   <= '0;
      height_r  <= '0;
      wide_r    <= 1'b0;
      tall_r    <= 1'b0;
      is8_r     <= 1'b0;
      row_r     <= '0;
      col_r     <= '0;
      pbi_r     <= '0;
      partial_r <= '0;
      pad_r     <= '0;
      base_r    <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      field_r   <= field_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      wide_r    <= wide_nxt;
      tall_r    <= tall_nxt;
      is8_r     <= is8_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pbi_r     <= pbi_nxt;
      partial_r <= partial_nxt;
      pad_r     <= pad_nxt;
      base_r    <= base_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmp_stream_decoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmp_stream_decoder
// Streaming BMP decoder for 24-bit and 8-bit palette images.
// ---------------------------------------------------------------------------
// One file byte is taken per word on the input channel, and a new byte is
// accepted every clock cycle as long as the result register is free or is
// being emptied in that cycle. A pixel or header error enters the result
// register when the byte that completes it is accepted; for 8-bit images the
// color comes from the palette RAM's single registered read port, which is
// read once per pixel byte and holds its data while the result waits.
// Palette entries are written by the 1024 palette bytes before any pixel is
// looked up; the RAM needs no clearing after reset.
module bmp_stream_decoder #(
  parameter int MAX_WIDTH  = bmpsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmpsd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [19:0]      out_pixel_address,
  output logic [31:0]      out_pixel_color,
  output logic [2:0]       out_error_code,
  output logic [10:0]      out_image_width,
  output logic [10:0]      out_image_height,
  output logic             out_last
);

  logic                  in_fire;
  logic                  res_valid;
  bmpsd_pkg::result_t    res;
  bmpsd_pkg::pal_wr_t    pal_wr;
  bmpsd_pkg::pal_rd_t    pal_rd;
  logic [bmpsd_pkg::PAL_DW-1:0] pal_rdata;

  logic                  out_valid_r;
  bmpsd_pkg::result_t    out_res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  bmpsd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .res_valid        (res_valid),
    .res              (res),
    .pal_wr           (pal_wr),
    .pal_rd           (pal_rd)
  );

  bmpsd_ram #(
    .WIDTH (bmpsd_pkg::PAL_DW),
    .DEPTH (bmpsd_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_wr.we),
    .waddr (pal_wr.addr),
    .wdata (pal_wr.data),
    .re    (pal_rd.re),
    .raddr (pal_rd.addr),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_res_r.kind;
  assign out_pixel_address = out_res_r.addr;
  assign out_pixel_color   = out_res_r.use_pal ? pal_rdata : out_res_r.color;
  assign out_error_code    = out_res_r.err;
  assign out_image_width   = out_res_r.width;
  assign out_image_height  = out_res_r.height;
  assign out_last          = out_res_r.last;

endmodule

`default_nettype wire

FILE: dv/bmp_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_stream_decoder_tb
// Self-checking bench for the BMP stream decoder.
// ---------------------------------------------------------------------------
// Builds BMP files byte by byte: good 24-bit and 8-bit palette images, files
// that fail each header check, zero-size images and a truncated file, all
// but the truncated one followed by up to three loose bytes. Every accepted
// byte goes through a local model of the parser. The model queues the pixel
// or error word that byte should produce, and the monitor compares each
// output word with the oldest queued one. Both ports idle at random, and the
// output port holds off long enough to back up the input.
// ---------------------------------------------------------------------------
module bmp_stream_decoder_tb;
  import bmpsd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [7:0] data;
    logic       sof;
  } file_byte_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] addr;
    logic [31:0] color;
    err_code_t   err;
    logic [10:0] width;
    logic [10:0] height;
    logic        is_last;
  } pixel_word_t;

  typedef enum logic [1:0] {PH_HEADER, PH_PALETTE, PH_PIXELS, PH_IDLE} parse_phase_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_start_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_result_kind;
  logic [19:0] out_pixel_address;
  logic [31:0] out_pixel_color;
  logic [2:0]  out_error_code;
  logic [10:0] out_image_width;
  logic [10:0] out_image_height;
  logic        out_last;

  bmp_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_error_code   (out_error_code),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_last         (out_last)
  );

  file_byte_t  file_bytes[$];
  pixel_word_t due_words[$];
  int          fail_cnt = 0;
  int          words_seen = 0;
  int          cycle_cnt;

  // parser model state
  parse_phase_t phase;
  logic [10:0]  byte_pos;
  logic [31:0]  field_acc;
  logic [31:0]  img_w;
  logic [31:0]  img_h;
  logic [15:0]  depth;
  logic [31:0]  palette[PALETTE_ENTRIES];
  logic [31:0]  row_idx;
  logic [31:0]  col_idx;
  logic [1:0]   rgb_idx;
  logic [15:0]  rgb_acc;
  int           pad_left;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic restart_parser();
    phase     = PH_HEADER;
    byte_pos  = '0;
    field_acc = '0;
    img_w     = '0;
    img_h     = '0;
    depth     = '0;
    row_idx   = '0;
    col_idx   = '0;
    rgb_idx   = '0;
    rgb_acc   = '0;
    pad_left  = 0;
  endtask

  task automatic emit_pixel(input logic [31:0] color);
    pixel_word_t w;
    logic [31:0] addr;
    int          rb;
    addr = (img_h - row_idx - 32'd1) * img_w + col_idx;
    w = '{KIND_PIXEL, addr[19:0], color, ERR_NONE, img_w[10:0], img_h[10:0], 1'b0};
    col_idx++;
    if (col_idx >= img_w) begin
      col_idx = '0;
      row_idx++;
      if (row_idx >= img_h) begin
        w.is_last = 1'b1;
        phase = PH_IDLE;
      end else begin
        rb = (depth == DEPTH_24) ? 3 * int'(img_w) : int'(img_w);
        pad_left = (4 - rb % 4) % 4;
      end
    end
    due_words.push_back(w);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    err_code_t   err;
    logic [31:0] k;
    err = ERR_NONE;
    if (sof) restart_parser();
    case (phase)
      PH_HEADER: begin
        field_acc = {b, field_acc[31:8]};
        case (byte_pos)
          POS_SIGNATURE: if (field_acc[31:16] != SIGNATURE) err = ERR_SIGNATURE;
          POS_FILE_SIZE: if (field_acc == 32'd0) err = ERR_ZERO_SIZE;
          POS_DATA_OFFSET: begin
            if (field_acc != HEADERS_END && field_acc != PALETTE_END) err = ERR_OFFSET;
          end
          POS_INFO_SIZE: if (field_acc != INFO_SIZE) err = ERR_INFO_SIZE;
          POS_WIDTH:  img_w = field_acc;
          POS_HEIGHT: img_h = field_acc;
          POS_DEPTH: begin
            if (field_acc[31:16] != DEPTH_8 && field_acc[31:16] != DEPTH_24) err = ERR_DEPTH;
            else depth = field_acc[31:16];
          end
          POS_COMPRESSION: begin
            if (field_acc > COMPR_MAX) err = ERR_COMPRESSION;
            else if (img_w > MAX_WIDTH_DEF || img_h > MAX_HEIGHT_DEF) err = ERR_TOO_LARGE;
          end
          default: ;
        endcase
        if (err != ERR_NONE) begin
          phase = PH_IDLE;
          due_words.push_back('{KIND_ERROR, 20'd0, 32'd0, err, 11'd0, 11'd0, 1'b0});
        end else begin
          if (byte_pos == POS_HEADER_LAST) begin
            if (img_w == 0 || img_h == 0) phase = PH_IDLE;
            else if (depth == DEPTH_8) phase = PH_PALETTE;
            else phase = PH_PIXELS;
          end
          byte_pos++;
        end
      end
      PH_PALETTE: begin
        k = byte_pos - HEADERS_END;
        field_acc = {b, field_acc[31:8]};
        if (k[1:0] == 2'd3) palette[k[9:2]] = field_acc;
        if (byte_pos == POS_PAL_LAST) phase = PH_PIXELS;
        byte_pos++;
      end
      PH_PIXELS: begin
        if (pad_left != 0) begin
          pad_left--;
        end else if (depth == DEPTH_8) begin
          emit_pixel(palette[b]);
        end else if (rgb_idx == 2'd0) begin
          rgb_acc = {8'd0, b};
          rgb_idx = 2'd1;
        end else if (rgb_idx == 2'd1) begin
          rgb_acc[15:8] = b;
          rgb_idx = 2'd2;
        end else begin
          rgb_idx = 2'd0;
          emit_pixel({8'd0, b, rgb_acc});
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_le(input logic [31:0] v, input int n, input bit sof);
    for (int i = 0; i < n; i++) file_bytes.push_back('{v[8*i +: 8], sof && (i == 0)});
  endtask

  task automatic add_file(input bit sof, input logic [15:0] sig, input logic [31:0] fsize,
                          input logic [31:0] offset, input logic [31:0] isize,
                          input logic [31:0] w, input logic [31:0] h,
                          input logic [15:0] bpp, input logic [31:0] compr, input bit body);
    int rb;
    int pad;
    push_le(sig, 2, sof);
    push_le(fsize, 4, 1'b0);
    push_le($urandom, 4, 1'b0);
    push_le(offset, 4, 1'b0);
    push_le(isize, 4, 1'b0);
    push_le(w, 4, 1'b0);
    push_le(h, 4, 1'b0);
    push_le($urandom, 2, 1'b0);
    push_le(bpp, 2, 1'b0);
    push_le(compr, 4, 1'b0);
    // a failing header is never read past its compression field
    if (body) repeat (20) push_le($urandom, 1, 1'b0);
    if (body && w != 0 && h != 0) begin
      if (bpp == DEPTH_8) repeat (1024) push_le($urandom, 1, 1'b0);
      rb = (bpp == DEPTH_24) ? 3 * int'(w) : int'(w);
      pad = (4 - rb % 4) % 4;
      for (int r = 0; r < int'(h); r++) begin
        for (int c = 0; c < int'(w); c++) begin
          if (bpp == DEPTH_8)
            push_le((r == 0 && c == 0) ? 32'd0 : (r == 0 && c == 1) ? 32'd255 : $urandom,
                    1, 1'b0);
          else
            push_le($urandom, 3, 1'b0);
        end
        repeat (pad) push_le($urandom, 1, 1'b0);
      end
    end
    repeat ($urandom_range(0, 3)) push_le($urandom, 1, 1'b0);
  endtask

  task automatic good_file(input bit sof, input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] bpp);
    add_file(sof, SIGNATURE, $urandom | 32'd1,
             $urandom_range(0, 1) ? HEADERS_END : PALETTE_END, INFO_SIZE, w, h, bpp,
             $urandom_range(0, 2), 1'b1);
  endtask

  task automatic bad_file(input err_code_t which);
    logic [15:0] sig;
    logic [15:0] bpp;
    logic [31:0] fsize;
    logic [31:0] offset;
    logic [31:0] isize;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] compr;
    sig    = SIGNATURE;
    fsize  = $urandom | 32'd1;
    offset = $urandom_range(0, 1) ? HEADERS_END : PALETTE_END;
    isize  = INFO_SIZE;
    w      = $urandom_range(1, 8);
    h      = $urandom_range(1, 8);
    bpp    = $urandom_range(0, 1) ? DEPTH_8 : DEPTH_24;
    compr  = $urandom_range(0, 2);
    case (which)
      ERR_SIGNATURE: sig = sig ^ (16'd1 << $urandom_range(0, 15));
      ERR_ZERO_SIZE: fsize = 32'd0;
      ERR_OFFSET: begin
        do offset = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000);
        while (offset == HEADERS_END || offset == PALETTE_END);
      end
      ERR_INFO_SIZE: begin
        do isize = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200);
        while (isize == INFO_SIZE);
      end
      ERR_DEPTH: begin
        do bpp = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 32));
        while (bpp == DEPTH_8 || bpp == DEPTH_24);
      end
      ERR_COMPRESSION: begin
        do compr = $urandom_range(0, 1) ? $urandom : $urandom_range(3, 9);
        while (compr <= COMPR_MAX);
      end
      ERR_TOO_LARGE: begin
        case ($urandom_range(0, 3))
          0: w = MAX_WIDTH_DEF + 1;
          1: h = MAX_HEIGHT_DEF + 1;
          2: h = ~h + 32'd1;
          default: w = $urandom_range(MAX_WIDTH_DEF + 1, 70000);
        endcase
      end
      default: ;
    endcase
    add_file(1'b1, sig, fsize, offset, isize, w, h, bpp, compr, 1'b0);
  endtask

  // driver: bursts of random length, random gaps in between
  int         burst_left;
  int         gap_left;
  logic       nxt_valid;
  logic [7:0] nxt_data;
  logic       nxt_sof;
  file_byte_t nxt_byte;

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parser();
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data_byte;
      nxt_sof   = in_start_of_file;
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_start_of_file);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (file_bytes.size() > 0) begin
          nxt_byte  = file_bytes.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = nxt_byte.data;
          nxt_sof   = nxt_byte.sof;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= nxt_valid;
      in_data_byte <= nxt_data;
      in_start_of_file <= nxt_sof;
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int          rx_tick;
  int          rx_hold;
  bit          hold_done = 1'b0;
  rx_pattern_t rx_mode;
  logic        rx_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_tick = 0;
      rx_hold = 0;
      rx_mode = RX_OPEN;
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
      if (!hold_done && words_seen >= 8) begin
        hold_done = 1'b1;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rx_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rx_next = 1'b1;
          RX_COIN:   rx_next = $urandom_range(0, 1);
          RX_SPARSE: rx_next = (rx_tick % 4 == 0);
          default:   rx_next = ($urandom_range(0, 9) != 0);
        endcase
      end
      out_ready <= rx_next;
    end
  end

  // monitor
  pixel_word_t got_word;
  pixel_word_t want_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen <= words_seen + 1;
      got_word = '{out_result_kind, out_pixel_address, out_pixel_color,
                   err_code_t'(out_error_code), out_image_width, out_image_height, out_last};
      if (due_words.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: unexpected word kind=%0d addr=%05h color=%08h err=%0d", $time,
                   got_word.kind, got_word.addr, got_word.color, got_word.err);
        fail_cnt++;
      end else begin
        want_word = due_words.pop_front();
        if (got_word.kind !== want_word.kind || got_word.addr !== want_word.addr ||
            got_word.color !== want_word.color || got_word.err !== want_word.err ||
            got_word.width !== want_word.width || got_word.height !== want_word.height ||
            got_word.is_last !== want_word.is_last) begin
          if (fail_cnt < 10) begin
            $display("%0t: mismatch exp kind=%0d addr=%05h color=%08h err=%0d w=%0d h=%0d last=%0d",
                     $time, want_word.kind, want_word.addr, want_word.color, want_word.err,
                     want_word.width, want_word.height, want_word.is_last);
            $display("%0t:          got kind=%0d addr=%05h color=%08h err=%0d w=%0d h=%0d last=%0d",
                     $time, got_word.kind, got_word.addr, got_word.color, got_word.err,
                     got_word.width, got_word.height, got_word.is_last);
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clk);
    $display("** bmp_stream_decoder: FAILED **");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first file starts without a start marker
    good_file(1'b0, 2, 2, DEPTH_24);
    for (int e = 1; e < 8; e++) bad_file(err_code_t'(e));
    good_file(1'b1, 0, 3, DEPTH_24);
    good_file(1'b1, 4, 0, DEPTH_8);
    // restart in the middle of the pixel data
    good_file(1'b1, 3, 3, DEPTH_24);
    repeat (15) void'(file_bytes.pop_back());

    while (file_bytes.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);

    good_file(1'b1, 13, 5, DEPTH_8);

    while (file_bytes.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && due_words.size() == 0)
      $display("** bmp_stream_decoder: PASSED **");
    else
      $display("** bmp_stream_decoder: FAILED **");
    $finish;
  end

endmodule
